@@ design/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants, codes and types of the address cache with retry table.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // default sizes
  localparam int CacheEntriesDef = 32;
  localparam int PendEntriesDef  = 16;

  // field widths
  localparam int IpW    = 32;
  localparam int MacW   = 48;
  localparam int StampW = 32;
  localparam int TmoW   = 16;
  localparam int TryW   = 4;
  localparam int KindW  = 3;
  localparam int CmdW   = 2;

  // configuration register reset values
  localparam logic [TmoW-1:0] TimeoutRst = 16'd15;
  localparam logic [TryW-1:0] RetryRst   = 4'd5;

  // configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_RETRY   = 1'b1;

  // input commands
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUEUE  = 2'd2;
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd3;

  // result kinds
  localparam logic [KindW-1:0] KIND_LOOKUP = 3'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 3'd1;
  localparam logic [KindW-1:0] KIND_QUEUE  = 3'd2;
  localparam logic [KindW-1:0] KIND_SEND   = 3'd3;
  localparam logic [KindW-1:0] KIND_GIVEUP = 3'd4;
  localparam logic [KindW-1:0] KIND_DONE   = 3'd5;

  // datapath operations
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_CAP     = 3'd1;
  localparam logic [2:0] OP_LK_SRCH = 3'd2;
  localparam logic [2:0] OP_LK_EMIT = 3'd3;
  localparam logic [2:0] OP_INS     = 3'd4;
  localparam logic [2:0] OP_QUE     = 3'd5;
  localparam logic [2:0] OP_AGE     = 3'd6;
  localparam logic [2:0] OP_WALK    = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic [2:0] op;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic walk_hit;
  } dp_sts_t;

endpackage

@@ design/arpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer that steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [arpc_pkg::CmdW-1:0] in_command_i,
  output logic                     in_ready_o,
  input  arpc_pkg::dp_sts_t        sts_i,
  output arpc_pkg::dp_ctl_t        ctl_o
);
  import arpc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LK_SRCH = 3'd1;
  localparam logic [2:0] S_LK_RD   = 3'd2;
  localparam logic [2:0] S_LK_EMIT = 3'd3;
  localparam logic [2:0] S_INS     = 3'd4;
  localparam logic [2:0] S_QUE     = 3'd5;
  localparam logic [2:0] S_AGE     = 3'd6;
  localparam logic [2:0] S_WALK    = 3'd7;

  logic [2:0] state_q, state_d;

  // next state and datapath command
  always_comb begin
    state_d    = state_q;
    ctl_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = OP_CAP;
          case (in_command_i)
            CMD_LOOKUP: state_d = S_LK_SRCH;
            CMD_INSERT: state_d = S_INS;
            CMD_QUEUE:  state_d = S_QUE;
            default:    state_d = S_AGE;
          endcase
        end
      end
      S_LK_SRCH: begin
        ctl_o.op = OP_LK_SRCH;
        state_d  = S_LK_RD;
      end
      S_LK_RD: state_d = S_LK_EMIT;
      S_LK_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_LK_EMIT;
          state_d  = S_IDLE;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_INS;
          state_d  = S_IDLE;
        end
      end
      S_QUE: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_QUE;
          state_d  = S_IDLE;
        end
      end
      S_AGE: begin
        ctl_o.op = OP_AGE;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_WALK;
          if (!sts_i.walk_hit) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/arpc_dp.sv @@
// ----------------------------------------------------------------------------
// arpc_dp
// Cache and pending tables, their search logic and the result register.
// ----------------------------------------------------------------------------
module arpc_dp #(
  parameter int CacheEntries = arpc_pkg::CacheEntriesDef,
  parameter int PendEntries  = arpc_pkg::PendEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [arpc_pkg::IpW-1:0]   in_ip_i,
  input  logic [arpc_pkg::MacW-1:0]  in_mac_i,
  input  logic [arpc_pkg::TmoW-1:0]  timeout_i,
  input  logic [arpc_pkg::TryW-1:0]  retry_i,
  input  arpc_pkg::dp_ctl_t          ctl_i,
  output arpc_pkg::dp_sts_t          sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [arpc_pkg::KindW-1:0] out_kind_o,
  output logic                       out_hit_o,
  output logic                       out_pending_found_o,
  output logic [arpc_pkg::IpW-1:0]   out_ip_res_o,
  output logic [arpc_pkg::MacW-1:0]  out_mac_res_o,
  output logic                       out_last_o
);
  import arpc_pkg::*;

  localparam int CIW = $clog2(CacheEntries);
  localparam int PIW = (PendEntries > 1) ? $clog2(PendEntries) : 1;
  localparam int PRW = $clog2(PendEntries + 1);

  // captured item
  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;

  // cache
  logic [CacheEntries-1:0] valid_q;
  logic [IpW-1:0]          eip_q   [CacheEntries];
  logic [StampW-1:0]       stamp_q [CacheEntries];
  logic [MacW-1:0]         mac_mem [CacheEntries];
  logic [StampW-1:0]       now_q;

  // pending table
  logic [PendEntries-1:0] pv_q;
  logic [IpW-1:0]         pip_q   [PendEntries];
  logic [TryW-1:0]        ptry_q  [PendEntries];
  logic [PRW-1:0]         prank_q [PendEntries];
  logic [PRW-1:0]         walk_q;

  // lookup
  logic [CIW-1:0]  lk_idx_q;
  logic            lk_hit_q;
  logic [MacW-1:0] mac_rd_q;

  // result register
  logic             ov_q;
  logic [KindW-1:0] okind_q;
  logic             ohit_q, opf_q, olast_q;
  logic [IpW-1:0]   oip_q;
  logic [MacW-1:0]  omac_q;

  // search results
  logic [CIW-1:0]    lk_idx, free_idx;
  logic              lk_hit, free_ok;
  logic [PIW-1:0]    pm_idx, pf_idx, wk_idx, rm_idx;
  logic              pm_hit, pf_ok, wk_hit, wk_send;
  logic [PRW-1:0]    rm_rank;
  logic [StampW-1:0] now_inc;
  logic [CacheEntries-1:0] expire;
  logic              load;

  assign now_inc = now_q + StampW'(1);

  // cache searches: highest matching entry, lowest free entry, aging
  always_comb begin
    lk_idx   = '0;
    lk_hit   = 1'b0;
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = 0; i < CacheEntries; i++) begin
      if (valid_q[i] && eip_q[i] == ip_q) begin
        lk_idx = CIW'(i);
        lk_hit = 1'b1;
      end
    end
    for (int i = CacheEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = CIW'(i);
        free_ok  = 1'b1;
      end
    end
    for (int i = 0; i < CacheEntries; i++) begin
      expire[i] = (now_inc - stamp_q[i]) > {{(StampW-TmoW){1'b0}}, timeout_i};
    end
  end

  // pending searches: address match, lowest free slot, walk position
  always_comb begin
    pm_idx = '0;
    pm_hit = 1'b0;
    pf_idx = '0;
    pf_ok  = 1'b0;
    wk_idx = '0;
    wk_hit = 1'b0;
    for (int i = PendEntries - 1; i >= 0; i--) begin
      if (pv_q[i] && pip_q[i] == ip_q) begin
        pm_idx = PIW'(i);
        pm_hit = 1'b1;
      end
      if (!pv_q[i]) begin
        pf_idx = PIW'(i);
        pf_ok  = 1'b1;
      end
      if (pv_q[i] && prank_q[i] == walk_q) begin
        wk_idx = PIW'(i);
        wk_hit = 1'b1;
      end
    end
  end

  assign wk_send = ptry_q[wk_idx] < retry_i;
  assign rm_idx  = (ctl_i.op == OP_WALK) ? wk_idx : pm_idx;
  assign rm_rank = prank_q[rm_idx];
  assign load    = (ctl_i.op == OP_LK_EMIT) || (ctl_i.op == OP_INS) ||
                   (ctl_i.op == OP_QUE) || (ctl_i.op == OP_WALK);

  assign sts_o.out_free = !ov_q || out_ready_i;
  assign sts_o.walk_hit = wk_hit;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pv_q    <= '0;
      now_q   <= '0;
      walk_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (ctl_i.op)
        OP_INS: begin
          if (pm_hit) pv_q[pm_idx] <= 1'b0;
          if (free_ok) valid_q[free_idx] <= 1'b1;
        end
        OP_QUE: begin
          if (!pm_hit && pf_ok) pv_q[pf_idx] <= 1'b1;
        end
        OP_AGE: begin
          now_q  <= now_inc;
          walk_q <= '0;
          valid_q <= valid_q & ~expire;
        end
        OP_WALK: begin
          if (wk_hit) begin
            if (wk_send) walk_q <= walk_q + PRW'(1);
            else pv_q[wk_idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // mac storage, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_INS && free_ok) mac_mem[free_idx] <= mac_q;
    mac_rd_q <= mac_mem[lk_idx_q];
  end

  // table contents and result payload
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_CAP: begin
        ip_q  <= in_ip_i;
        mac_q <= in_mac_i;
      end
      OP_LK_SRCH: begin
        lk_idx_q <= lk_idx;
        lk_hit_q <= lk_hit;
      end
      OP_LK_EMIT: begin
        okind_q <= KIND_LOOKUP;
        ohit_q  <= lk_hit_q;
        opf_q   <= 1'b0;
        oip_q   <= ip_q;
        omac_q  <= lk_hit_q ? mac_rd_q : '0;
        olast_q <= 1'b1;
      end
      OP_INS: begin
        if (free_ok) begin
          eip_q[free_idx]   <= ip_q;
          stamp_q[free_idx] <= now_q;
        end
        if (pm_hit) begin
          for (int i = 0; i < PendEntries; i++) begin
            if (pv_q[i] && prank_q[i] > rm_rank) prank_q[i] <= prank_q[i] - PRW'(1);
          end
        end
        okind_q <= KIND_INSERT;
        ohit_q  <= free_ok;
        opf_q   <= pm_hit;
        oip_q   <= ip_q;
        omac_q  <= '0;
        olast_q <= 1'b1;
      end
      OP_QUE: begin
        if (!pm_hit && pf_ok) begin
          for (int i = 0; i < PendEntries; i++) begin
            if (pv_q[i]) prank_q[i] <= prank_q[i] + PRW'(1);
          end
          pip_q[pf_idx]   <= ip_q;
          ptry_q[pf_idx]  <= '0;
          prank_q[pf_idx] <= '0;
        end
        okind_q <= KIND_QUEUE;
        ohit_q  <= pm_hit || pf_ok;
        opf_q   <= 1'b0;
        oip_q   <= ip_q;
        omac_q  <= '0;
        olast_q <= 1'b1;
      end
      OP_WALK: begin
        ohit_q <= 1'b0;
        opf_q  <= 1'b0;
        omac_q <= '0;
        if (wk_hit) begin
          oip_q   <= pip_q[wk_idx];
          olast_q <= 1'b0;
          if (wk_send) begin
            okind_q        <= KIND_SEND;
            ptry_q[wk_idx] <= ptry_q[wk_idx] + TryW'(1);
          end else begin
            okind_q <= KIND_GIVEUP;
            for (int i = 0; i < PendEntries; i++) begin
              if (pv_q[i] && prank_q[i] > rm_rank) prank_q[i] <= prank_q[i] - PRW'(1);
            end
          end
        end else begin
          okind_q <= KIND_DONE;
          oip_q   <= '0;
          olast_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o         = ov_q;
  assign out_kind_o          = okind_q;
  assign out_hit_o           = ohit_q;
  assign out_pending_found_o = opf_q;
  assign out_ip_res_o        = oip_q;
  assign out_mac_res_o       = omac_q;
  assign out_last_o          = olast_q;

endmodule

@@ design/arp_cache_with_retry_table.sv @@
// ----------------------------------------------------------------------------
// arp_cache_with_retry_table
// Address cache with aging and a pending-request table with retry counting.
// ----------------------------------------------------------------------------
// One item is handled at a time. A lookup steps through capture, parallel
// compare, mac memory read and result, insert and queue through capture and
// result, and a tick through capture, aging, one result per pending request
// and the done result; the sequencer walks the pending table newest first,
// one request per cycle while the output is free. Each result waits in an
// output register while the consumer stalls; reset needs no clearing pass.
// ----------------------------------------------------------------------------
module arp_cache_with_retry_table #(
  parameter int CACHE_ENTRIES   = arpc_pkg::CacheEntriesDef,
  parameter int PENDING_ENTRIES = arpc_pkg::PendEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [arpc_pkg::CmdW-1:0]  in_command_i,
  input  logic [arpc_pkg::IpW-1:0]   in_ip_i,
  input  logic [arpc_pkg::MacW-1:0]  in_mac_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [arpc_pkg::KindW-1:0] out_kind_o,
  output logic                       out_hit_o,
  output logic                       out_pending_found_o,
  output logic [arpc_pkg::IpW-1:0]   out_ip_res_o,
  output logic [arpc_pkg::MacW-1:0]  out_mac_res_o,
  output logic                       out_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import arpc_pkg::*;

  logic [TmoW-1:0] timeout_q;
  logic [TryW-1:0] retry_q;
  dp_ctl_t         ctl;
  dp_sts_t         sts;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      retry_q   <= RetryRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TIMEOUT) timeout_q <= pwdata[TmoW-1:0];
      else retry_q <= pwdata[TryW-1:0];
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == REG_TIMEOUT) prdata = {{(32-TmoW){1'b0}}, timeout_q};
    else prdata = {{(32-TryW){1'b0}}, retry_q};
  end

  arpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_command_i),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .ctl_o        (ctl)
  );

  arpc_dp #(
    .CacheEntries (CACHE_ENTRIES),
    .PendEntries  (PENDING_ENTRIES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_ip_i             (in_ip_i),
    .in_mac_i            (in_mac_i),
    .timeout_i           (timeout_q),
    .retry_i             (retry_q),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .out_kind_o          (out_kind_o),
    .out_hit_o           (out_hit_o),
    .out_pending_found_o (out_pending_found_o),
    .out_ip_res_o        (out_ip_res_o),
    .out_mac_res_o       (out_mac_res_o),
    .out_last_o          (out_last_o)
  );

endmodule

@@ design/arpc_checker.sv @@
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [arpc_pkg::KindW-1:0] out_kind_o,
  input logic                       out_hit_o,
  input logic                       out_pending_found_o,
  input logic [arpc_pkg::IpW-1:0]   out_ip_res_o,
  input logic [arpc_pkg::MacW-1:0]  out_mac_res_o,
  input logic                       out_last_o
);
  import arpc_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o) && $stable(out_ip_res_o))
    else $error("result changed while stalled");

  // tick walk results never end the item, done always does
  a_walk_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_SEND || out_kind_o == KIND_GIVEUP) |-> !out_last_o)
    else $error("send or give-up marked last");

  // only an insert reports a removed request
  a_pf_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_pending_found_o |-> out_kind_o == KIND_INSERT)
    else $error("pending flag on wrong kind");

  // a mac comes back only on a lookup hit
  a_mac_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_mac_res_o != '0) |-> out_kind_o == KIND_LOOKUP && out_hit_o)
    else $error("mac without lookup hit");

  // no new item is taken while a non-final result is outstanding
  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> !(in_valid_i && in_ready_o))
    else $error("item accepted during tick walk");

endmodule

bind arp_cache_with_retry_table arpc_checker u_arpc_checker (.*);

@@ verif/tb_arp_cache_with_retry_table.sv @@
// ----------------------------------------------------------------------------
// tb_arp_cache_with_retry_table
// Self-checking bench for the address cache with aging and retry table.
// Every item that the block accepts is run through a behavioural model of the
// cache and pending table, and the results that it predicts are compared field
// by field with the results that the block delivers. The run covers several
// register settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_arp_cache_with_retry_table;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  localparam int NCache = 32;
  localparam int NPend  = 16;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } arp_req_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             hit;
    logic             pf;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic             last;
  } arp_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [CmdW-1:0] in_command_i;
  logic [IpW-1:0] in_ip_i;
  logic [MacW-1:0] in_mac_i;
  logic out_valid_o, out_ready_i;
  logic [KindW-1:0] out_kind_o;
  logic out_hit_o, out_pending_found_o, out_last_o;
  logic [IpW-1:0] out_ip_res_o;
  logic [MacW-1:0] out_mac_res_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  arp_cache_with_retry_table u_dut (.*);

  // cache and pending table mirror
  logic            c_valid [NCache];
  logic [IpW-1:0]  c_ip    [NCache];
  logic [MacW-1:0] c_mac   [NCache];
  logic [31:0]     c_stamp [NCache];
  logic [31:0]     now_q;
  logic            p_valid [NPend];
  logic [IpW-1:0]  p_ip    [NPend];
  logic [TryW-1:0] p_tries [NPend];
  logic [3:0]      p_rank  [NPend];
  logic [TmoW-1:0] timeout_q;
  logic [TryW-1:0] retry_q;

  arp_req_t req_q[$];
  arp_res_t expected_q[$];
  int fails;
  int idle_pct, stall_pct;
  logic [IpW-1:0] ip_pool [24];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // drop a pending request and close the gap in the age order
  task automatic pend_drop(input int s);
    p_valid[s] = 1'b0;
    for (int i = 0; i < NPend; i++)
      if (p_valid[i] && p_rank[i] > p_rank[s]) p_rank[i]--;
  endtask

  function automatic int pend_lookup(input logic [IpW-1:0] ip);
    for (int i = 0; i < NPend; i++)
      if (p_valid[i] && p_ip[i] == ip) return i;
    return -1;
  endfunction

  task automatic push_res(input logic [KindW-1:0] k, input logic h, input logic pf,
                          input logic [IpW-1:0] ip, input logic [MacW-1:0] mac,
                          input logic last);
    arp_res_t r;
    r.kind = k; r.hit = h; r.pf = pf; r.ip = ip; r.mac = mac; r.last = last;
    expected_q.push_back(r);
  endtask

  // work out the results of one accepted item and update the mirror
  task automatic arp_predict(input arp_req_t q);
    int found, slot, p, cnt;
    int order[NPend];
    found = -1; slot = -1; cnt = 0;
    case (q.cmd)
      CMD_LOOKUP: begin
        for (int i = 0; i < NCache; i++)
          if (c_valid[i] && c_ip[i] == q.ip) found = i;
        push_res(KIND_LOOKUP, found >= 0, 1'b0, q.ip, found >= 0 ? c_mac[found] : '0, 1'b1);
      end
      CMD_INSERT: begin
        p = pend_lookup(q.ip);
        if (p >= 0) pend_drop(p);
        for (int i = NCache - 1; i >= 0; i--)
          if (!c_valid[i]) slot = i;
        if (slot >= 0) begin
          c_valid[slot] = 1'b1; c_ip[slot] = q.ip;
          c_mac[slot] = q.mac; c_stamp[slot] = now_q;
        end
        push_res(KIND_INSERT, slot >= 0, p >= 0, q.ip, '0, 1'b1);
      end
      CMD_QUEUE: begin
        found = 1;
        if (pend_lookup(q.ip) < 0) begin
          for (int i = NPend - 1; i >= 0; i--)
            if (!p_valid[i]) slot = i;
          if (slot < 0) begin
            found = 0;
          end else begin
            for (int i = 0; i < NPend; i++)
              if (p_valid[i]) p_rank[i]++;
            p_valid[slot] = 1'b1; p_ip[slot] = q.ip;
            p_tries[slot] = '0; p_rank[slot] = '0;
          end
        end
        push_res(KIND_QUEUE, found[0], 1'b0, q.ip, '0, 1'b1);
      end
      default: begin
        now_q = now_q + 1;
        for (int i = 0; i < NCache; i++)
          if (c_valid[i] && (now_q - c_stamp[i]) > {16'd0, timeout_q}) c_valid[i] = 1'b0;
        // newest request first
        for (int r = 0; r < NPend; r++)
          for (int i = 0; i < NPend; i++)
            if (p_valid[i] && p_rank[i] == r) begin
              order[cnt++] = i;
              break;
            end
        for (int r = 0; r < cnt; r++) begin
          if (p_tries[order[r]] < retry_q) begin
            p_tries[order[r]]++;
            push_res(KIND_SEND, 1'b0, 1'b0, p_ip[order[r]], '0, 1'b0);
          end else begin
            push_res(KIND_GIVEUP, 1'b0, 1'b0, p_ip[order[r]], '0, 1'b0);
            pend_drop(order[r]);
          end
        end
        push_res(KIND_DONE, 1'b0, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // driver: sends queued items, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    arp_req_t nx;
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        arp_predict('{in_command_i, in_ip_i, in_mac_i});
        busy = 1'b0;
      end
      if (!busy) begin
        if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nx = req_q.pop_front();
          in_command_i <= nx.cmd;
          in_ip_i <= nx.ip;
          in_mac_i <= nx.mac;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each delivered result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    arp_res_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0d ip %h", out_kind_o, out_ip_res_o);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (out_kind_o !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, out_kind_o); fails++;
          end
          if (out_hit_o !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, out_hit_o); fails++;
          end
          if (out_pending_found_o !== e.pf) begin
            $error("pending_found: expected %0d actual %0d", e.pf, out_pending_found_o);
            fails++;
          end
          if (out_ip_res_o !== e.ip) begin
            $error("ip_res: expected %h actual %h", e.ip, out_ip_res_o); fails++;
          end
          if (out_mac_res_o !== e.mac) begin
            $error("mac_res: expected %h actual %h", e.mac, out_mac_res_o); fails++;
          end
          if (out_last_o !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_last_o); fails++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // register write over the configuration port
  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_TIMEOUT) timeout_q = val[TmoW-1:0];
    else retry_q = val[TryW-1:0];
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [MacW-1:0] rand_mac();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [IpW-1:0] pick_ip();
    if ($urandom_range(99) < 15) return $urandom();
    return ip_pool[$urandom_range(23)];
  endfunction

  // random items; insert weight shapes how full the cache gets
  task automatic add_random(input int n, input int ins_w);
    arp_req_t q;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30) q.cmd = CMD_LOOKUP;
      else if (r < 30 + ins_w) q.cmd = CMD_INSERT;
      else if (r < 85) q.cmd = CMD_QUEUE;
      else q.cmd = CMD_TICK;
      q.ip = pick_ip();
      q.mac = rand_mac();
      req_q.push_back(q);
    end
  endtask

  task automatic add_item(input logic [CmdW-1:0] c, input logic [IpW-1:0] ip,
                          input logic [MacW-1:0] mac);
    req_q.push_back('{c, ip, mac});
  endtask

  initial begin
    fails = 0; idle_pct = 0; stall_pct = 0;
    now_q = '0; timeout_q = TimeoutRst; retry_q = RetryRst;
    for (int i = 0; i < NCache; i++) c_valid[i] = 1'b0;
    for (int i = 0; i < NPend; i++) p_valid[i] = 1'b0;
    ip_pool[0] = '0; ip_pool[1] = '1;
    for (int i = 2; i < 24; i++) ip_pool[i] = $urandom();
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0;
    in_command_i = '0; in_ip_i = '0; in_mac_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, duplicates, pending full, retries with reset settings
    add_item(CMD_LOOKUP, '0, '0);
    add_item(CMD_INSERT, '0, '1);
    add_item(CMD_INSERT, '1, '0);
    add_item(CMD_INSERT, '0, 48'h0123_4567_89ab);
    add_item(CMD_LOOKUP, '0, '1);
    add_item(CMD_LOOKUP, '1, '0);
    add_item(CMD_QUEUE, '1, '0);
    add_item(CMD_QUEUE, '1, '0);
    for (int i = 0; i < NPend; i++) add_item(CMD_QUEUE, 32'h0a00_0000 + i, '0);
    add_item(CMD_INSERT, 32'h0a00_0003, '1);
    for (int i = 0; i < 7; i++) add_item(CMD_TICK, $urandom(), rand_mac());
    add_item(CMD_LOOKUP, 32'h0a00_0003, '0);
    for (int i = 0; i < 12; i++) add_item(CMD_TICK, '0, '0);
    add_item(CMD_LOOKUP, '0, '0);
    wait_drained();

    // long timeout, full retry count: cache fills up
    reg_write(REG_TIMEOUT, 32'd65535);
    reg_write(REG_RETRY, 32'd15);
    idle_pct = 63;
    add_random(90, 40);
    wait_drained();

    // timeout of 1, immediate give-up
    reg_write(REG_TIMEOUT, 32'd1);
    reg_write(REG_RETRY, 32'd0);
    idle_pct = 0; stall_pct = 63;
    add_random(80, 25);
    wait_drained();

    // middle settings, both sides idling
    reg_write(REG_TIMEOUT, 32'd7);
    reg_write(REG_RETRY, 32'd3);
    idle_pct = 27; stall_pct = 27;
    add_random(80, 25);
    wait_drained();

    // back to reset values, no idling
    reg_write(REG_TIMEOUT, {16'd0, TimeoutRst});
    reg_write(REG_RETRY, {28'd0, RetryRst});
    idle_pct = 0; stall_pct = 0;
    add_random(60, 20);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (fails == 0 && expected_q.size() == 0) begin
      $display("PASS arp_cache_with_retry_table");
    end else begin
      $display("FAIL arp_cache_with_retry_table");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("FAIL arp_cache_with_retry_table");
    $finish;
  end

endmodule
